// ===== src/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, masked while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== src/arpc_pkg.sv =====
// Types, constants and codes of the ARP cache and responder.
`default_nettype none

package arpc_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int IP_W          = 32;
    localparam int MAC_W         = 48;
    localparam int CFG_IDX_W     = 2;

    // header field values
    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [7:0]  MAC_LEN     = 8'd6;
    localparam logic [7:0]  IPV4_LEN    = 8'd4;
    localparam logic [15:0] OP_REQUEST  = 16'd1;

    // status codes
    localparam logic [2:0] STATUS_OK             = 3'd0;
    localparam logic [2:0] STATUS_BAD_HW_TYPE    = 3'd1;
    localparam logic [2:0] STATUS_BAD_HW_LEN     = 3'd2;
    localparam logic [2:0] STATUS_BAD_PROTO_TYPE = 3'd3;
    localparam logic [2:0] STATUS_BAD_PROTO_LEN  = 3'd4;

    // table action codes
    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_UPDATED = 2'd1;
    localparam logic [1:0] ACT_ADDED   = 2'd2;
    localparam logic [1:0] ACT_FULL    = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MAC = 2'd1;

    // lookup token walking down the cell row
    typedef struct packed {
        logic             valid;
        logic             hit;    // matching entry found and refreshed
        logic             added;  // pair written into the first free cell
        logic [CNT_W-1:0] rem;    // occupied cells still ahead of the token
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } t_token;

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } t_state;

endpackage

`default_nettype wire

// ===== src/arpc_cell.sv =====
// One cache entry: compares, refreshes or claims itself as the token passes.
`default_nettype none

module arpc_cell (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  arpc_pkg::t_token      i_tok,
    output arpc_pkg::t_token      o_tok
);

    logic [arpc_pkg::IP_W-1:0]  r_ip;
    logic [arpc_pkg::MAC_W-1:0] r_mac;
    arpc_pkg::t_token           r_tok;
    arpc_pkg::t_token           n_tok;
    logic                       live;
    logic                       occupied;
    logic                       hit_here;
    logic                       add_here;

    always_comb begin
        live     = i_tok.valid && !i_tok.hit && !i_tok.added;
        occupied = (i_tok.rem != '0);
        hit_here = live && occupied && (r_ip == i_tok.ip);
        add_here = live && !occupied;
        n_tok       = i_tok;
        n_tok.hit   = i_tok.hit | hit_here;
        n_tok.added = i_tok.added | add_here;
        if (occupied) begin
            n_tok.rem = i_tok.rem - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hit_here || add_here) begin
            r_mac <= i_tok.mac;
        end
        if (add_here) begin
            r_ip <= i_tok.ip;
        end
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// ===== src/arp_cache_and_responder.sv =====
// Top level: header check, cell-row ARP cache and reply addressing.
`default_nettype none

// Usage
// - Item channel: drive the parsed ARP header fields and pulse start; the item
//   is taken at a clock edge with start high and busy low.
// - Result channel: o_done is high for exactly one cycle with the result
//   fields. There is no back-pressure; the receiver must take every beat.
// - Config channel: i_cfg_valid / o_cfg_ready with i_cfg_index (0 local IP,
//   1 local MAC) and i_cfg_data. Ready is always high. Write only while idle.
// - A header error gives its result the cycle after acceptance.
//   A valid header sends a lookup token down a row of TABLE_ENTRIES cells,
//   one cell per cycle; the result comes when the token leaves the last
//   cell, and busy stays high until then.
// - Only one item is in flight: no new item is accepted until the token has
//   walked the cell row, but a new item may be accepted while a result beat
//   is on the outputs.
// - Reset (synchronous, active low) empties the cache (entry count zero),
//   clears the local IP and MAC and drops any item in flight.
module arp_cache_and_responder (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire  [15:0]                       i_hw_type,
    input  wire  [15:0]                       i_proto_type,
    input  wire  [7:0]                        i_hw_len,
    input  wire  [7:0]                        i_proto_len,
    input  wire  [15:0]                       i_op_code,
    input  wire  [arpc_pkg::MAC_W-1:0]        i_sender_mac,
    input  wire  [arpc_pkg::IP_W-1:0]         i_sender_ip,
    input  wire  [arpc_pkg::IP_W-1:0]         i_target_ip,
    output logic                              o_done,
    output logic [2:0]                        o_status,
    output logic [1:0]                        o_table_action,
    output logic                              o_new_destination,
    output logic                              o_reply_valid,
    output logic [arpc_pkg::MAC_W-1:0]        o_reply_dest_mac,
    output logic [arpc_pkg::IP_W-1:0]         o_reply_src_ip,
    output logic [arpc_pkg::IP_W-1:0]         o_reply_dest_ip,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [arpc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [arpc_pkg::MAC_W-1:0]        i_cfg_data
);

    // configuration
    logic [arpc_pkg::IP_W-1:0]  r_local_ip;
    logic [arpc_pkg::MAC_W-1:0] r_local_mac;   // held for the reply frame builder

    // control
    arpc_pkg::t_state           r_state, n_state;
    logic [arpc_pkg::CNT_W-1:0] r_count, n_count;
    logic                       r_reply_due, n_reply_due;

    // result beat
    logic                       r_done, n_done;
    logic [2:0]                 r_status, n_status;
    logic [1:0]                 r_action, n_action;
    logic                       r_newdest, n_newdest;
    logic                       r_rvalid, n_rvalid;
    logic [arpc_pkg::MAC_W-1:0] r_rmac, n_rmac;
    logic [arpc_pkg::IP_W-1:0]  r_rsip, n_rsip;
    logic [arpc_pkg::IP_W-1:0]  r_rdip, n_rdip;

    logic                       accept;
    logic [2:0]                 head_status;
    arpc_pkg::t_token           tok [0:arpc_pkg::TABLE_ENTRIES];
    arpc_pkg::t_token           tail;

    assign busy        = (r_state == arpc_pkg::S_SEARCH);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // first header mismatch wins
    always_comb begin
        if (i_hw_type != arpc_pkg::HW_ETHERNET) begin
            head_status = arpc_pkg::STATUS_BAD_HW_TYPE;
        end else if (i_hw_len != arpc_pkg::MAC_LEN) begin
            head_status = arpc_pkg::STATUS_BAD_HW_LEN;
        end else if (i_proto_type != arpc_pkg::PROTO_IPV4) begin
            head_status = arpc_pkg::STATUS_BAD_PROTO_TYPE;
        end else if (i_proto_len != arpc_pkg::IPV4_LEN) begin
            head_status = arpc_pkg::STATUS_BAD_PROTO_LEN;
        end else begin
            head_status = arpc_pkg::STATUS_OK;
        end
    end

    // token injected at the head of the row on a clean header
    always_comb begin
        tok[0].valid = accept && (head_status == arpc_pkg::STATUS_OK);
        tok[0].hit   = 1'b0;
        tok[0].added = 1'b0;
        tok[0].rem   = r_count;
        tok[0].ip    = i_sender_ip;
        tok[0].mac   = i_sender_mac;
    end

    for (genvar g = 0; g < arpc_pkg::TABLE_ENTRIES; g++) begin : g_cell
        arpc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1])
        );
    end

    assign tail = tok[arpc_pkg::TABLE_ENTRIES];

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_reply_due = r_reply_due;
        n_done      = 1'b0;
        n_status    = r_status;
        n_action    = r_action;
        n_newdest   = r_newdest;
        n_rvalid    = r_rvalid;
        n_rmac      = r_rmac;
        n_rsip      = r_rsip;
        n_rdip      = r_rdip;
        case (r_state)
            arpc_pkg::S_IDLE: begin
                if (accept) begin
                    if (head_status == arpc_pkg::STATUS_OK) begin
                        n_state     = arpc_pkg::S_SEARCH;
                        n_reply_due = (i_target_ip == r_local_ip) &&
                                      (i_op_code == arpc_pkg::OP_REQUEST);
                    end else begin
                        // header error: result next cycle, cache untouched
                        n_done    = 1'b1;
                        n_status  = head_status;
                        n_action  = arpc_pkg::ACT_NONE;
                        n_newdest = 1'b0;
                        n_rvalid  = 1'b0;
                        n_rmac    = '0;
                        n_rsip    = '0;
                        n_rdip    = '0;
                    end
                end
            end
            arpc_pkg::S_SEARCH: begin
                if (tail.valid) begin
                    n_state   = arpc_pkg::S_IDLE;
                    n_done    = 1'b1;
                    n_status  = arpc_pkg::STATUS_OK;
                    n_newdest = tail.added;
                    if (tail.hit) begin
                        n_action = arpc_pkg::ACT_UPDATED;
                    end else if (tail.added) begin
                        n_action = arpc_pkg::ACT_ADDED;
                        n_count  = r_count + 1'b1;
                    end else begin
                        n_action = arpc_pkg::ACT_FULL;
                    end
                    n_rvalid = r_reply_due;
                    n_rmac   = r_reply_due ? tail.mac : '0;
                    n_rsip   = r_reply_due ? r_local_ip : '0;
                    n_rdip   = r_reply_due ? tail.ip : '0;
                end
            end
            default: begin
                n_state = arpc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= arpc_pkg::S_IDLE;
            r_count     <= '0;
            r_done      <= 1'b0;
            r_local_ip  <= '0;
            r_local_mac <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == arpc_pkg::CFG_LOCAL_IP) begin
                    r_local_ip <= i_cfg_data[arpc_pkg::IP_W-1:0];
                end else if (i_cfg_index == arpc_pkg::CFG_LOCAL_MAC) begin
                    r_local_mac <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_reply_due <= n_reply_due;
        r_status    <= n_status;
        r_action    <= n_action;
        r_newdest   <= n_newdest;
        r_rvalid    <= n_rvalid;
        r_rmac      <= n_rmac;
        r_rsip      <= n_rsip;
        r_rdip      <= n_rdip;
    end

    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_table_action    = r_action;
    assign o_new_destination = r_newdest;
    assign o_reply_valid     = r_rvalid;
    assign o_reply_dest_mac  = r_rmac;
    assign o_reply_src_ip    = r_rsip;
    assign o_reply_dest_ip   = r_rdip;

endmodule

`default_nettype wire

// ===== src/arpc_checker.sv =====
// Port-level checks of the ARP cache and responder, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module arpc_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            start,
    input wire                            busy,
    input wire                            o_done,
    input wire [2:0]                      o_status,
    input wire [1:0]                      o_table_action,
    input wire                            o_new_destination,
    input wire                            o_reply_valid,
    input wire [arpc_pkg::MAC_W-1:0]      o_reply_dest_mac,
    input wire [arpc_pkg::IP_W-1:0]       o_reply_src_ip,
    input wire [arpc_pkg::IP_W-1:0]       o_reply_dest_ip
);

    // an accepted item either starts a lookup or reports a header error
    `ASSERT_NEXT(a_accept_acts, i_clk, i_rst_n, start && !busy, busy || o_done)

    // every result beat follows an acceptance or the end of a lookup
    `ASSERT_IMPLY(a_done_has_cause, i_clk, i_rst_n, o_done, $past(busy) || $past(start))

    // header errors leave the cache and the reply path quiet
    `ASSERT_IMPLY(a_error_quiet, i_clk, i_rst_n,
        o_done && (o_status != arpc_pkg::STATUS_OK),
        (o_table_action == arpc_pkg::ACT_NONE) && !o_new_destination && !o_reply_valid)

    // a newly resolved destination is always an added entry
    `ASSERT_IMPLY(a_newdest_added, i_clk, i_rst_n, o_done && o_new_destination,
        o_table_action == arpc_pkg::ACT_ADDED)

    // no reply addressing without a reply
    `ASSERT_IMPLY(a_reply_fields, i_clk, i_rst_n, o_done && !o_reply_valid,
        (o_reply_dest_mac == '0) && (o_reply_src_ip == '0) && (o_reply_dest_ip == '0))

endmodule

bind arp_cache_and_responder arpc_checker u_arpc_checker (.*);

`default_nettype wire

// ===== tb/arp_tb_pkg.sv =====
// Packet and result types plus the cache mirror class for the ARP testbench.
`timescale 1ns / 1ps

package arp_tb_pkg;

    import arpc_pkg::*;

    localparam logic [15:0] OP_REPLY = 16'd2;

    typedef struct packed {
        logic [15:0]      hw_type;
        logic [15:0]      proto_type;
        logic [7:0]       hw_len;
        logic [7:0]       proto_len;
        logic [15:0]      op_code;
        logic [MAC_W-1:0] sender_mac;
        logic [IP_W-1:0]  sender_ip;
        logic [IP_W-1:0]  target_ip;
    } arp_header_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [1:0]       table_action;
        logic             new_destination;
        logic             reply_valid;
        logic [MAC_W-1:0] reply_dest_mac;
        logic [IP_W-1:0]  reply_src_ip;
        logic [IP_W-1:0]  reply_dest_ip;
    } arp_outcome_t;

    // Mirror of the station's ARP cache; predicts each outcome and matches result beats.
    class arp_cache_mirror;
        logic [IP_W-1:0]  ip_tbl[TABLE_ENTRIES];
        logic [MAC_W-1:0] mac_tbl[TABLE_ENTRIES];
        int               fill;
        logic [IP_W-1:0]  station_ip;
        logic [MAC_W-1:0] station_mac;
        arp_outcome_t     due_outcomes[$];
        int               n_checked;
        int               n_failed;
        int               n_added;
        int               n_refreshed;
        int               n_dropped;
        int               n_replies;
        int               n_bad_hdr;

        function new();
            fill        = 0;
            station_ip  = '0;
            station_mac = '0;
            n_checked   = 0;
            n_failed    = 0;
            n_added     = 0;
            n_refreshed = 0;
            n_dropped   = 0;
            n_replies   = 0;
            n_bad_hdr   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [MAC_W-1:0] data);
            if (idx == CFG_LOCAL_IP) begin
                station_ip = data[IP_W-1:0];
            end else if (idx == CFG_LOCAL_MAC) begin
                station_mac = data;
            end
        endfunction

        function void take_packet(arp_header_t h);
            arp_outcome_t o;
            int           hit_at;
            int           i;
            o      = '0;
            hit_at = -1;
            if (h.hw_type != HW_ETHERNET) begin
                o.status = STATUS_BAD_HW_TYPE;
            end else if (h.hw_len != MAC_LEN) begin
                o.status = STATUS_BAD_HW_LEN;
            end else if (h.proto_type != PROTO_IPV4) begin
                o.status = STATUS_BAD_PROTO_TYPE;
            end else if (h.proto_len != IPV4_LEN) begin
                o.status = STATUS_BAD_PROTO_LEN;
            end else begin
                o.status = STATUS_OK;
            end

            if (o.status != STATUS_OK) begin
                n_bad_hdr++;
            end else begin
                for (i = 0; i < fill; i++) begin
                    if (hit_at < 0 && ip_tbl[i] == h.sender_ip) hit_at = i;
                end
                if (hit_at >= 0) begin
                    mac_tbl[hit_at] = h.sender_mac;
                    o.table_action  = ACT_UPDATED;
                    n_refreshed++;
                end else if (fill < TABLE_ENTRIES) begin
                    ip_tbl[fill]      = h.sender_ip;
                    mac_tbl[fill]     = h.sender_mac;
                    fill++;
                    o.table_action    = ACT_ADDED;
                    o.new_destination = 1'b1;
                    n_added++;
                end else begin
                    o.table_action = ACT_FULL;
                    n_dropped++;
                end
                if (h.target_ip == station_ip && h.op_code == OP_REQUEST) begin
                    o.reply_valid    = 1'b1;
                    o.reply_dest_mac = h.sender_mac;
                    o.reply_src_ip   = station_ip;
                    o.reply_dest_ip  = h.sender_ip;
                    n_replies++;
                end
            end
            due_outcomes.push_back(o);
        endfunction

        function void flag(string what, arp_outcome_t want, arp_outcome_t got);
            n_failed++;
            if (n_failed <= 10) begin
                $display("MISMATCH %0s", what);
                $display("  expected st=%0d act=%0d new=%b rv=%b mac=%h sip=%h dip=%h",
                         want.status, want.table_action, want.new_destination,
                         want.reply_valid, want.reply_dest_mac, want.reply_src_ip,
                         want.reply_dest_ip);
                $display("  actual   st=%0d act=%0d new=%b rv=%b mac=%h sip=%h dip=%h",
                         got.status, got.table_action, got.new_destination,
                         got.reply_valid, got.reply_dest_mac, got.reply_src_ip,
                         got.reply_dest_ip);
            end
        endfunction

        function void match_outcome(arp_outcome_t got);
            arp_outcome_t want;
            string        bad;
            if (due_outcomes.size() == 0) begin
                flag("result beat with no packet outstanding", '0, got);
                return;
            end
            want = due_outcomes.pop_front();
            n_checked++;
            bad = "";
            if (got.status !== want.status)                   bad = {bad, " status"};
            if (got.table_action !== want.table_action)       bad = {bad, " table_action"};
            if (got.new_destination !== want.new_destination) bad = {bad, " new_destination"};
            if (got.reply_valid !== want.reply_valid)         bad = {bad, " reply_valid"};
            if (got.reply_dest_mac !== want.reply_dest_mac)   bad = {bad, " reply_dest_mac"};
            if (got.reply_src_ip !== want.reply_src_ip)       bad = {bad, " reply_src_ip"};
            if (got.reply_dest_ip !== want.reply_dest_ip)     bad = {bad, " reply_dest_ip"};
            if (bad != "") flag({"in", bad}, want, got);
        endfunction
    endclass

endpackage

// ===== tb/testbench.sv =====
// Top-level testbench of the ARP cache and responder: stimulus, monitor and verdict.
`timescale 1ns / 1ps

module testbench;

    import arpc_pkg::*;
    import arp_tb_pkg::*;

    localparam int HALF_PERIOD      = 5;
    localparam int STALL_LIMIT      = 1000;  // cycles with no beat of any kind
    localparam int N_PHASES         = 6;
    localparam int RANDOM_PER_PHASE = 322;
    localparam int POOL_SIZE        = 48;    // more than the table holds, so it fills up
    localparam int MAX_GAP          = 36;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [15:0]          i_hw_type;
    logic [15:0]          i_proto_type;
    logic [7:0]           i_hw_len;
    logic [7:0]           i_proto_len;
    logic [15:0]          i_op_code;
    logic [MAC_W-1:0]     i_sender_mac;
    logic [IP_W-1:0]      i_sender_ip;
    logic [IP_W-1:0]      i_target_ip;
    logic                 o_done;
    logic [2:0]           o_status;
    logic [1:0]           o_table_action;
    logic                 o_new_destination;
    logic                 o_reply_valid;
    logic [MAC_W-1:0]     o_reply_dest_mac;
    logic [IP_W-1:0]      o_reply_src_ip;
    logic [IP_W-1:0]      o_reply_dest_ip;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [MAC_W-1:0]     i_cfg_data;

    arp_cache_mirror      sb;
    int                   idle_pct;     // percent of packets preceded by a sender gap
    int                   n_sent = 0;
    int                   stall_cycles = 0;
    logic [IP_W-1:0]      ip_pool[POOL_SIZE];

    always #HALF_PERIOD i_clk = ~i_clk;

    arp_cache_and_responder dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_hw_type         (i_hw_type),
        .i_proto_type      (i_proto_type),
        .i_hw_len          (i_hw_len),
        .i_proto_len       (i_proto_len),
        .i_op_code         (i_op_code),
        .i_sender_mac      (i_sender_mac),
        .i_sender_ip       (i_sender_ip),
        .i_target_ip       (i_target_ip),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_table_action    (o_table_action),
        .o_new_destination (o_new_destination),
        .o_reply_valid     (o_reply_valid),
        .o_reply_dest_mac  (o_reply_dest_mac),
        .o_reply_src_ip    (o_reply_src_ip),
        .o_reply_dest_ip   (o_reply_dest_ip),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // Result monitor: o_done marks a one-cycle beat; the receiver never holds off,
    // so every beat seen at a rising edge is taken and checked right away.
    always @(posedge i_clk) begin
        arp_outcome_t seen;
        if (i_rst_n && o_done) begin
            seen.status          = o_status;
            seen.table_action    = o_table_action;
            seen.new_destination = o_new_destination;
            seen.reply_valid     = o_reply_valid;
            seen.reply_dest_mac  = o_reply_dest_mac;
            seen.reply_src_ip    = o_reply_src_ip;
            seen.reply_dest_ip   = o_reply_dest_ip;
            sb.match_outcome(seen);
        end
    end

    // Watchdog: any packet beat, result beat or register write restarts the count.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // Both registers back to back; valid stays high across the two beats.
    // Upper data bits are junk for the 32-bit IP register and must be ignored.
    task automatic load_station(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
        logic [MAC_W-1:0] ip_word;
        ip_word = {16'($urandom()), ip};
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_LOCAL_IP;
        i_cfg_data  <= ip_word;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(CFG_LOCAL_IP, ip_word);
        i_cfg_index <= CFG_LOCAL_MAC;
        i_cfg_data  <= mac;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(CFG_LOCAL_MAC, mac);
        i_cfg_valid <= 1'b0;
    endtask

    // One packet beat. An optional gap first drops start; otherwise start stays
    // high from the previous beat and the fields simply change.
    task automatic send_packet(input arp_header_t p);
        int gap;
        gap = ($urandom_range(99, 0) < idle_pct) ? $urandom_range(MAX_GAP, 1) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_hw_type    <= p.hw_type;
        i_proto_type <= p.proto_type;
        i_hw_len     <= p.hw_len;
        i_proto_len  <= p.proto_len;
        i_op_code    <= p.op_code;
        i_sender_mac <= p.sender_mac;
        i_sender_ip  <= p.sender_ip;
        i_target_ip  <= p.target_ip;
        do @(posedge i_clk); while (busy);
        sb.take_packet(p);
        n_sent++;
    endtask

    // Wait out every outstanding result, then the walk of one more token.
    task automatic drain();
        start <= 1'b0;
        while (sb.due_outcomes.size() != 0) @(posedge i_clk);
        repeat (TABLE_ENTRIES + 2) @(posedge i_clk);
    endtask

    function automatic arp_header_t good_packet(input logic [MAC_W-1:0] mac,
                                                input logic [IP_W-1:0] sip,
                                                input logic [IP_W-1:0] tip,
                                                input logic [15:0] op);
        arp_header_t p;
        p.hw_type    = HW_ETHERNET;
        p.proto_type = PROTO_IPV4;
        p.hw_len     = MAC_LEN;
        p.proto_len  = IPV4_LEN;
        p.op_code    = op;
        p.sender_mac = mac;
        p.sender_ip  = sip;
        p.target_ip  = tip;
        return p;
    endfunction

    // Mostly clean headers from a small address pool so hits and the full table
    // are reached; the rest carry one corrupted field or a fully random header.
    function automatic arp_header_t random_packet();
        arp_header_t p;
        logic [63:0] r64;
        int unsigned roll;
        r64 = {$urandom(), $urandom()};
        p = good_packet(r64[MAC_W-1:0], '0, '0, OP_REQUEST);
        roll = $urandom_range(99, 0);
        if (roll < 12) begin
            case ($urandom_range(3, 0))
                0:       p.hw_type    = p.hw_type ^ 16'($urandom_range(16'hFFFF, 1));
                1:       p.hw_len     = p.hw_len ^ 8'($urandom_range(8'hFF, 1));
                2:       p.proto_type = p.proto_type ^ 16'($urandom_range(16'hFFFF, 1));
                default: p.proto_len  = p.proto_len ^ 8'($urandom_range(8'hFF, 1));
            endcase
        end else if (roll < 20) begin
            r64 = {$urandom(), $urandom()};
            p.hw_type    = r64[15:0];
            p.proto_type = r64[31:16];
            p.hw_len     = r64[39:32];
            p.proto_len  = r64[47:40];
        end

        roll = $urandom_range(9, 0);
        if (roll < 6)      p.op_code = OP_REQUEST;
        else if (roll < 8) p.op_code = OP_REPLY;
        else               p.op_code = 16'($urandom());

        if ($urandom_range(3, 0) != 0) p.sender_ip = ip_pool[$urandom_range(POOL_SIZE - 1, 0)];
        else                           p.sender_ip = $urandom();

        // target: our address, a one-bit near miss, or anything
        roll = $urandom_range(9, 0);
        if (roll < 5)      p.target_ip = sb.station_ip;
        else if (roll < 6) p.target_ip = sb.station_ip ^ (32'd1 << $urandom_range(31, 0));
        else               p.target_ip = $urandom();
        return p;
    endfunction

    // Directed opener; expects the station IP to be all ones at this point.
    task automatic directed_packets();
        arp_header_t      p;
        logic [IP_W-1:0]  me;
        logic [MAC_W-1:0] ones;
        me   = sb.station_ip;
        ones = '1;
        // first sighting of address zero, request for us: added plus reply
        send_packet(good_packet('0, '0, me, OP_REQUEST));
        // same sender again as a reply op: MAC refreshed, no reply
        send_packet(good_packet(ones, '0, me, OP_REPLY));
        // all-ones sender asking for someone else
        send_packet(good_packet(ones, '1, '0, OP_REQUEST));
        send_packet(good_packet({$urandom(), 16'($urandom())}, '1, me, OP_REQUEST));
        // each header check at both extremes
        p = good_packet(ones, 32'h0a00_0001, me, OP_REQUEST);
        p.hw_type = '0;    send_packet(p);
        p.hw_type = '1;    send_packet(p);
        p = good_packet(ones, 32'h0a00_0001, me, OP_REQUEST);
        p.hw_len = '0;     send_packet(p);
        p.hw_len = '1;     send_packet(p);
        p = good_packet(ones, 32'h0a00_0001, me, OP_REQUEST);
        p.proto_type = '0; send_packet(p);
        p.proto_type = '1; send_packet(p);
        p = good_packet(ones, 32'h0a00_0001, me, OP_REQUEST);
        p.proto_len = '0;  send_packet(p);
        p.proto_len = '1;  send_packet(p);
        // check priority: every field wrong, then length and protocol both wrong
        p.hw_type = '0; p.hw_len = '0; p.proto_type = '0; send_packet(p);
        p.hw_type = HW_ETHERNET; send_packet(p);
        // unknown opcodes and a near-miss target never get a reply
        send_packet(good_packet('0, 32'h0a00_0002, me, 16'h0000));
        send_packet(good_packet('0, 32'h0a00_0002, me, 16'hffff));
        send_packet(good_packet(ones, 32'h0a00_0003, me ^ 32'h1, OP_REQUEST));
    endtask

    initial begin
        logic [IP_W-1:0]  ip_set;
        logic [MAC_W-1:0] mac_set;
        int               phase;
        sb           = new();
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_hw_type    = '0;
        i_proto_type = '0;
        i_hw_len     = '0;
        i_proto_len  = '0;
        i_op_code    = '0;
        i_sender_mac = '0;
        i_sender_ip  = '0;
        i_target_ip  = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_LOCAL_IP;
        i_cfg_data   = '0;
        idle_pct     = 0;

        ip_pool[0] = '0;
        ip_pool[1] = '1;
        for (int k = 2; k < POOL_SIZE; k++) ip_pool[k] = $urandom();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Phases: all-ones and all-zeros station first, then random settings.
        // Sender gaps: 31% for two phases, 50% for two, none for the last two.
        for (phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0: begin
                    ip_set  = '1;
                    mac_set = '1;
                end
                1: begin
                    ip_set  = '0;
                    mac_set = '0;
                end
                N_PHASES - 1: begin
                    // station shares an address with pool senders
                    ip_set  = ip_pool[2];
                    mac_set = {16'($urandom()), $urandom()};
                end
                default: begin
                    ip_set  = $urandom();
                    mac_set = {16'($urandom()), $urandom()};
                end
            endcase
            load_station(ip_set, mac_set);
            idle_pct = (phase < 2) ? 31 : (phase < 4) ? 50 : 0;
            if (phase == 0) directed_packets();
            repeat (RANDOM_PER_PHASE) send_packet(random_packet());
            drain();
        end

        $display("covered %0d packets over %0d station settings: %0d added, %0d refreshed, %0d dropped",
                 n_sent, N_PHASES, sb.n_added, sb.n_refreshed, sb.n_dropped);
        $display("%0d header errors, %0d replies; %0d results checked, %0d failures",
                 sb.n_bad_hdr, sb.n_replies, sb.n_checked, sb.n_failed);
        if (sb.n_failed == 0 && sb.due_outcomes.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
